// ===== rtl/abw_pkg.sv =====
// abw_pkg: shared types, constants and register indexes for the affine bilinear warp.
// No dependencies; imported by every module of the block except abw_ram.
`timescale 1ns / 1ps
package abw_pkg;
  localparam int MaxWidth  = 512;
  localparam int MaxHeight = 512;
  localparam int FracBits  = 14;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int AddrW     = ColW + RowW;
  localparam int Depth     = MaxWidth * MaxHeight;
  localparam int CfgW      = 23;
  localparam int IdxW      = 3;
  // position: Q4 delta (14b signed) * 18b coeff -> 32b, /16, sum of two + 23b centre
  localparam int PosW      = 34;

  localparam logic [IdxW-1:0] RegSin  = 3'd0;
  localparam logic [IdxW-1:0] RegCos  = 3'd1;
  localparam logic [IdxW-1:0] RegSrcX = 3'd2;
  localparam logic [IdxW-1:0] RegSrcY = 3'd3;
  localparam logic [IdxW-1:0] RegDstX = 3'd4;
  localparam logic [IdxW-1:0] RegDstY = 3'd5;
  localparam logic [IdxW-1:0] RegWid  = 3'd6;
  localparam logic [IdxW-1:0] RegHgt  = 3'd7;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel_value;
    logic [8:0] column;
    logic [8:0] row;
  } in_req_t;

  typedef struct packed {
    logic [7:0] warped_value;
    logic       outside;
  } out_req_t;

  typedef struct packed {
    logic signed [17:0] sin_coeff;
    logic signed [17:0] cos_coeff;
    logic [22:0]        src_center_x;
    logic [22:0]        src_center_y;
    logic [12:0]        dst_center_x;
    logic [12:0]        dst_center_y;
    logic [9:0]         image_width;
    logic [9:0]         image_height;
  } cfg_t;

  // truncate toward zero a product divided by 16
  function automatic logic signed [PosW-1:0] div16(input logic signed [31:0] p);
    logic signed [31:0] q;
    q = (p < 0) ? -((-p) >>> 4) : (p >>> 4);
    return PosW'(q);
  endfunction

  // a + ((b-a)*w + half) >> F, result low 8 bits
  function automatic logic [7:0] lerp(input logic [7:0] a, input logic [7:0] b,
                                      input logic [FracBits-1:0] w);
    logic signed [FracBits+10:0] s;
    s = $signed({3'b0, a, {FracBits{1'b0}}})
      + ($signed({1'b0, b}) - $signed({1'b0, a})) * $signed({1'b0, w})
      + $signed((FracBits+11)'(1) <<< (FracBits-1));
    return s[FracBits+7:FracBits];
  endfunction
endpackage

// ===== rtl/affine_bilinear_warp.sv =====
// affine_bilinear_warp: top level; coordinate pipe, frame store, interpolation, output.
// Depends on abw_pkg, abw_coord, abw_store.
`timescale 1ns / 1ps
// Usage:
//  - in_ channel carries requests: mode 0 writes a source pixel at (column,row),
//    mode 1 asks for the warped destination pixel at (column,row).
//  - out_ channel returns one result per mode 1 request: warped_value and outside.
//  - cfg_ port writes coefficient, centre and size registers by index; write
//    only while no request is in flight.
//  - Throughput: one request per clock while out_stall does not hold the pipe.
//    Results pass seven register stages: 3 coordinate, 1 RAM read,
//    2 interpolation, 1 output; the first loads at the accepting edge.
//  - The frame store is four copies of the full frame, one per neighbour, so
//    all four taps read in the same cycle; writes go to every copy.
//  - Source writes travel down a delay line and reach the store at the stage
//    where reads happen, so reads and writes keep their request order.
//  - When a result waits under out_stall the whole pipe holds, in_stall rises,
//    and no request is lost or repeated. Reset clears valid bits and restores
//    the register defaults; the frame content is undefined until written.
module affine_bilinear_warp import abw_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_req_t         in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output out_req_t        out_data,
  input  logic            cfg_we,
  input  logic [IdxW-1:0] cfg_index,
  input  logic [CfgW-1:0] cfg_wdata
);
  cfg_t cfg_r;
  logic en, in_acc;

  logic c_vld, c_rd, c_out;
  logic [ColW-1:0] x0, x1;
  logic [RowW-1:0] y0, y1;
  logic [FracBits-1:0] wx, wy;
  logic [7:0] p00, p10, p01, p11;

  // write delay line, aligned with the coordinate stages
  logic wv1_r, wv2_r, wv3_r;
  in_req_t wq1_r, wq2_r, wq3_r;

  // stage after RAM read
  logic v4_r, o4_r;
  logic [FracBits-1:0] wx4_r, wy4_r;
  // horizontal lerp
  logic v5_r, o5_r;
  logic [FracBits-1:0] wy5_r;
  logic [7:0] h0_r, h1_r;
  // vertical lerp
  logic v6_r;
  out_req_t r6_r;
  // output register
  logic ov_r;
  out_req_t od_r;

  // advance the whole pipe unless a held result blocks
  assign en       = !(ov_r && out_stall);
  assign in_stall = !en;
  assign in_acc   = in_valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sin_coeff    <= '0;
      cfg_r.cos_coeff    <= 18'sd16384;
      cfg_r.src_center_x <= '0;
      cfg_r.src_center_y <= '0;
      cfg_r.dst_center_x <= '0;
      cfg_r.dst_center_y <= '0;
      cfg_r.image_width  <= 10'd512;
      cfg_r.image_height <= 10'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        RegSin:  cfg_r.sin_coeff    <= cfg_wdata[17:0];
        RegCos:  cfg_r.cos_coeff    <= cfg_wdata[17:0];
        RegSrcX: cfg_r.src_center_x <= cfg_wdata;
        RegSrcY: cfg_r.src_center_y <= cfg_wdata;
        RegDstX: cfg_r.dst_center_x <= cfg_wdata[12:0];
        RegDstY: cfg_r.dst_center_y <= cfg_wdata[12:0];
        RegWid:  cfg_r.image_width  <= cfg_wdata[9:0];
        RegHgt:  cfg_r.image_height <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  abw_coord u_coord (
    .clk(clk), .rst_n(rst_n), .en(en), .cfg(cfg_r),
    .in_vld(in_acc), .in_req(in_data),
    .out_vld(c_vld), .out_rd(c_rd), .out_outside(c_out),
    .out_x0(x0), .out_x1(x1), .out_y0(y0), .out_y1(y1),
    .out_wx(wx), .out_wy(wy)
  );

  // delay writes so they land at the read stage; column/row always fit the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv1_r <= 1'b0;
      wv2_r <= 1'b0;
      wv3_r <= 1'b0;
    end else if (en) begin
      wv1_r <= in_acc && !in_data.mode;
      wv2_r <= wv1_r;
      wv3_r <= wv2_r;
    end
    if (en) begin
      wq1_r <= in_data;
      wq2_r <= wq1_r;
      wq3_r <= wq2_r;
    end
  end

  abw_store u_store (
    .clk(clk), .en(en),
    .wr_en(en && wv3_r), .wr_col(wq3_r.column), .wr_row(wq3_r.row),
    .wr_data(wq3_r.pixel_value),
    .x0(x0), .x1(x1), .y0(y0), .y1(y1),
    .p00(p00), .p10(p10), .p01(p01), .p11(p11)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (en) begin
        v4_r <= c_vld && c_rd;
        v5_r <= v4_r;
        v6_r <= v5_r;
      end
      if (!ov_r || !out_stall) begin
        ov_r <= v6_r && en;
      end
    end
    if (en) begin
      o4_r  <= c_out;
      wx4_r <= wx;
      wy4_r <= wy;
      o5_r  <= o4_r;
      wy5_r <= wy4_r;
      h0_r  <= lerp(p00, p10, wx4_r);
      h1_r  <= lerp(p01, p11, wx4_r);
      r6_r.outside      <= o5_r;
      r6_r.warped_value <= o5_r ? 8'd0 : lerp(h0_r, h1_r, wy5_r);
      od_r <= r6_r;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  // outside results carry zero
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outside |-> out_data.warped_value == 8'd0)
    else $error("outside result not zero");
  // input stalls only when a result is held
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("spurious input stall");
endmodule

// ===== rtl/abw_ram.sv =====
// abw_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module abw_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ===== rtl/abw_coord.sv =====
// abw_coord: three-stage source-coordinate pipeline (delta, products, sums/bounds).
// Depends on abw_pkg.
`timescale 1ns / 1ps
module abw_coord import abw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  cfg_t             cfg,
  input  logic             in_vld,
  input  in_req_t          in_req,
  output logic             out_vld,
  output logic             out_rd,
  output logic             out_outside,
  output logic [ColW-1:0]  out_x0,
  output logic [ColW-1:0]  out_x1,
  output logic [RowW-1:0]  out_y0,
  output logic [RowW-1:0]  out_y1,
  output logic [FracBits-1:0] out_wx,
  output logic [FracBits-1:0] out_wy
);
  // stage 1: deltas
  logic v1_r, rd1_r;
  logic signed [13:0] dx_r, dy_r;
  // stage 2: products
  logic v2_r, rd2_r;
  logic signed [PosW-1:0] pxc_r, pys_r, pyc_r, pxs_r;
  // stage 3: position
  logic v3_r, rd3_r, out3_r;
  logic [ColW-1:0] x0_r, x1_r;
  logic [RowW-1:0] y0_r, y1_r;
  logic [FracBits-1:0] wx_r, wy_r;

  logic signed [PosW-1:0] fx_nxt, fy_nxt;
  logic signed [PosW-FracBits-1:0] ix, iy;
  logic [10:0] w_sat, h_sat;

  always_comb begin
    fx_nxt = pxc_r + pys_r + PosW'(cfg.src_center_x);
    fy_nxt = pyc_r - pxs_r + PosW'(cfg.src_center_y);
    ix = fx_nxt[PosW-1:FracBits];
    iy = fy_nxt[PosW-1:FracBits];
    w_sat = (cfg.image_width > 10'(MaxWidth)) ? 11'(MaxWidth) : 11'(cfg.image_width);
    h_sat = (cfg.image_height > 10'(MaxHeight)) ? 11'(MaxHeight) : 11'(cfg.image_height);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    if (en) begin
      rd1_r <= in_req.mode;
      dx_r  <= $signed({1'b0, in_req.column, 4'b0}) - $signed({1'b0, cfg.dst_center_x});
      dy_r  <= $signed({1'b0, in_req.row, 4'b0}) - $signed({1'b0, cfg.dst_center_y});
      rd2_r <= rd1_r;
      pxc_r <= div16(32'(dx_r) * 32'(cfg.cos_coeff));
      pys_r <= div16(32'(dy_r) * 32'(cfg.sin_coeff));
      pyc_r <= div16(32'(dy_r) * 32'(cfg.cos_coeff));
      pxs_r <= div16(32'(dx_r) * 32'(cfg.sin_coeff));
      rd3_r <= rd2_r;
      out3_r <= fx_nxt[PosW-1] || fy_nxt[PosW-1]
             || (ix >= (PosW-FracBits)'(w_sat)) || (iy >= (PosW-FracBits)'(h_sat));
      x0_r <= ColW'(ix);
      y0_r <= RowW'(iy);
      x1_r <= (ix + 1 < (PosW-FracBits)'(w_sat)) ? ColW'(ix + 1) : ColW'(w_sat - 11'd1);
      y1_r <= (iy + 1 < (PosW-FracBits)'(h_sat)) ? RowW'(iy + 1) : RowW'(h_sat - 11'd1);
      wx_r <= fx_nxt[FracBits-1:0];
      wy_r <= fy_nxt[FracBits-1:0];
    end
  end

  assign out_vld     = v3_r;
  assign out_rd      = rd3_r;
  assign out_outside = out3_r;
  assign out_x0 = x0_r;
  assign out_x1 = x1_r;
  assign out_y0 = y0_r;
  assign out_y1 = y1_r;
  assign out_wx = wx_r;
  assign out_wy = wy_r;
endmodule

// ===== rtl/abw_store.sv =====
// abw_store: source frame in four RAM copies, one per bilinear neighbour.
// Depends on abw_pkg and abw_ram.
`timescale 1ns / 1ps
module abw_store import abw_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic            wr_en,
  input  logic [ColW-1:0] wr_col,
  input  logic [RowW-1:0] wr_row,
  input  logic [7:0]      wr_data,
  input  logic [ColW-1:0] x0,
  input  logic [ColW-1:0] x1,
  input  logic [RowW-1:0] y0,
  input  logic [RowW-1:0] y1,
  output logic [7:0]      p00,
  output logic [7:0]      p10,
  output logic [7:0]      p01,
  output logic [7:0]      p11
);
  logic [AddrW-1:0] ra [4];
  logic [7:0]       rd [4];

  assign ra[0] = {y0, x0};
  assign ra[1] = {y0, x1};
  assign ra[2] = {y1, x0};
  assign ra[3] = {y1, x1};

  for (genvar g = 0; g < 4; g++) begin : g_bank
    abw_ram #(.Width(8), .Depth(Depth)) u_ram (
      .clk(clk), .wr_en(wr_en), .wr_addr({wr_row, wr_col}), .wr_data(wr_data),
      .rd_en(en), .rd_addr(ra[g]), .rd_data(rd[g])
    );
  end

  assign p00 = rd[0];
  assign p10 = rd[1];
  assign p01 = rd[2];
  assign p11 = rd[3];
endmodule
